// ----- src/plrl_pkg.sv -----
package plrl_pkg;

  localparam int KEY_W   = 26;
  localparam int CNT_W   = 10;
  localparam int FB_W    = 8;
  localparam int EPOCH_W = 4;

  localparam logic [1:0] V_VISIBLE   = 2'd0;
  localparam logic [1:0] V_ADULT     = 2'd1;
  localparam logic [1:0] V_CLUSTERED = 2'd2;
  localparam logic [1:0] V_OVERFLOW  = 2'd3;

  localparam logic [1:0] CFG_MAX_PER_SITE = 2'd0;
  localparam logic [1:0] CFG_CLUSTERING   = 2'd1;
  localparam logic [1:0] CFG_FAMILY       = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic             lookup;
    logic [1:0]       verdict;
    logic             used_fb;
    logic [KEY_W-1:0] key;
    logic             last;
  } item_t;

  // one table entry, live when its epoch matches the current one
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [CNT_W-1:0]   count;
  } entry_t;

endpackage

// ----- src/plrl_front.sv -----
module plrl_front (
  input  logic                      adult_flag,
  input  logic                      lookup_failed,
  input  logic [25:0]               site_hash,
  input  logic [7:0]                fallback_hash,
  input  logic                      last_in_list,
  input  logic                      site_clustering_on,
  input  logic                      family_filter_on,
  output plrl_pkg::item_t           item
);

  logic hide;

  always_comb begin
    hide         = family_filter_on & adult_flag;
    item.lookup  = ~hide & site_clustering_on;
    item.verdict = hide ? plrl_pkg::V_ADULT : plrl_pkg::V_VISIBLE;
    item.used_fb = item.lookup & lookup_failed;
    item.key     = lookup_failed ?
                   {{(plrl_pkg::KEY_W-plrl_pkg::FB_W){1'b0}}, fallback_hash} : site_hash;
    item.last    = last_in_list;
  end

endmodule

// ----- src/plrl_queue.sv -----
module plrl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  plrl_pkg::item_t push_data,
  output logic            full,
  input  logic            pop,
  output plrl_pkg::item_t pop_data,
  output logic            empty
);

  plrl_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/plrl_back.sv -----
module plrl_back #(
  parameter int TABLE_SLOTS = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [plrl_pkg::CNT_W-1:0]   max_per_site,
  input  logic                         q_empty,
  input  plrl_pkg::item_t              q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   verdict,
  output logic                         used_fallback
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0] LAST_PROBE = CW'(TABLE_SLOTS - 1);
  localparam logic [plrl_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [plrl_pkg::EPOCH_W-1:0] EPOCH_FIRST = plrl_pkg::EPOCH_W'(1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  plrl_pkg::entry_t mem [TABLE_SLOTS];
  plrl_pkg::entry_t rd_data;

  logic [2:0]                    state;
  logic [IW-1:0]                 idx;
  logic [CW-1:0]                 probes;
  logic [plrl_pkg::EPOCH_W-1:0]  epoch;
  plrl_pkg::item_t               cur;
  logic [1:0]                    res;

  logic                          we;
  plrl_pkg::entry_t              wd;
  logic                          live;
  logic                          hit;
  logic                          under;
  logic                          out_free;
  logic [IW-1:0]                 idx_inc;
  logic [IW-1:0]                 home;

  // home slot: fold the key, then bring it below the slot count
  function automatic logic [IW-1:0] home_slot(input logic [plrl_pkg::KEY_W-1:0] k);
    logic [IW-1:0] h;
    h = k[IW-1:0] ^ k[2*IW-1:IW];
    if (h > LAST_IDX) h = h - LAST_IDX - IW'(1);
    return h;
  endfunction

  always_comb begin
    live     = (rd_data.epoch == epoch);
    hit      = live && (rd_data.key == cur.key);
    under    = (rd_data.count < max_per_site);
    out_free = ~out_valid | ~out_stall;
    idx_inc  = (idx == LAST_IDX) ? '0 : idx + IW'(1);
    home     = home_slot(q_data.key);
    q_pop    = (state == S_IDLE) && ~q_empty;
    we       = 1'b0;
    wd       = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_CMP) begin
      if (hit && under) begin
        we = 1'b1;
        wd = '{epoch: epoch, key: cur.key, count: rd_data.count + plrl_pkg::CNT_W'(1)};
      end else if (!live && max_per_site != '0) begin
        we = 1'b1;
        wd = '{epoch: epoch, key: cur.key, count: plrl_pkg::CNT_W'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wd;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      probes    <= '0;
      epoch     <= EPOCH_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          idx <= idx_inc;
          if (idx == LAST_IDX) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur    <= q_data;
            res    <= q_data.verdict;
            idx    <= home;
            probes <= '0;
            state  <= q_data.lookup ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            res   <= under ? plrl_pkg::V_VISIBLE : plrl_pkg::V_CLUSTERED;
            state <= S_DONE;
          end else if (!live) begin
            res   <= (max_per_site == '0) ? plrl_pkg::V_CLUSTERED : plrl_pkg::V_VISIBLE;
            state <= S_DONE;
          end else if (probes == LAST_PROBE) begin
            res   <= (max_per_site == '0) ? plrl_pkg::V_CLUSTERED : plrl_pkg::V_OVERFLOW;
            state <= S_DONE;
          end else begin
            probes <= probes + CW'(1);
            idx    <= idx_inc;
            state  <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            verdict       <= res;
            used_fallback <= cur.used_fb;
            if (cur.last && epoch == EPOCH_MAX) begin
              epoch <= EPOCH_FIRST;
              idx   <= '0;
              state <= S_CLEAR;
            end else begin
              state <= S_IDLE;
              if (cur.last) epoch <= epoch + plrl_pkg::EPOCH_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/per_site_result_limiter_unit.sv -----
// a result that needs no table lookup skips the hash table; one that does may take extra
//   probes of the hash table; one table memory port is read, compared, then written per probe
// the back end handles one result at a time
// reset: synchronous, clears control state and sweeps every table slot,
//   again after every 15th end of list when the epoch mark wraps; no item leaves the queue then
module per_site_result_limiter_unit #(
  parameter int TABLE_SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        adult_flag,
  input  logic        lookup_failed,
  input  logic [25:0] site_hash,
  input  logic [7:0]  fallback_hash,
  input  logic        last_in_list,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic        used_fallback
);

  // configuration registers
  logic [9:0] max_per_site;
  logic       site_clustering_on;
  logic       family_filter_on;

  plrl_pkg::item_t front_item;
  plrl_pkg::item_t q_data;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            push;

  // config is always taken, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_site       <= 10'd2;
      site_clustering_on <= 1'b1;
      family_filter_on   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        plrl_pkg::CFG_MAX_PER_SITE: max_per_site       <= cfg_data;
        plrl_pkg::CFG_CLUSTERING:   site_clustering_on <= cfg_data[0];
        plrl_pkg::CFG_FAMILY:       family_filter_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: classify each beat into a direct verdict or a table lookup
  plrl_front u_front (
    .adult_flag         (adult_flag),
    .lookup_failed      (lookup_failed),
    .site_hash          (site_hash),
    .fallback_hash      (fallback_hash),
    .last_in_list       (last_in_list),
    .site_clustering_on (site_clustering_on),
    .family_filter_on   (family_filter_on),
    .item               (front_item)
  );

  // stall only when the queue is full
  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  plrl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: hash table probe, count update, result register
  plrl_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .max_per_site  (max_per_site),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .used_fallback (used_fallback)
  );

endmodule
